// ----- rtl/bsrs_pkg.sv -----
// Package for the bitmap set-bit and run scanner.
// Holds the bitmap size, item kinds, controller/datapath command types and bit helpers.
// Used by every file in the rtl folder except bsrs_if.
package bsrs_pkg;

   localparam int BitmapBytes = 4096;
   localparam int AddrWidth   = $clog2(BitmapBytes);
   localparam int CeilWidth   = 13;
   localparam int CountWidth  = 16;

   localparam logic [CeilWidth-1:0] CeilReset = CeilWidth'(4096);
   localparam logic [CeilWidth-1:0] CeilLimit = CeilWidth'(BitmapBytes);

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_FIND  = 2'd1,
      KIND_RUN   = 2'd2,
      KIND_SPARE = 2'd3
   } kind_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

   // Bits below the given index are set.
   function automatic logic [7:0] low_mask(input logic [2:0] bit_idx);
      return ~(8'hFF << bit_idx);
   endfunction

   function automatic logic [3:0] trailing_ones(input logic [7:0] x);
      logic [3:0] n;
      logic       stop;
      n    = '0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!stop) begin
            if (x[i]) begin
               n = n + 4'd1;
            end else begin
               stop = 1'b1;
            end
         end
      end
      return n;
   endfunction

   function automatic logic [2:0] lowest_set(input logic [7:0] x);
      logic [2:0] r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         if (x[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/bsrs_if.sv -----
// Channel interfaces for the bitmap set-bit and run scanner.
// Request, response and control-register write channels; depends on nothing.
interface bsrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [11:0] byte_index;
   logic [7:0]  byte_value;
   logic [2:0]  start_bit;

   modport source (output valid, kind, byte_index, byte_value, start_bit, input ready);
   modport sink   (input valid, kind, byte_index, byte_value, start_bit, output ready);
endinterface

interface bsrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [11:0] found_byte_addr;
   logic [2:0]  found_bit;
   logic [15:0] run_length;
   logic        run_is_ones;
   logic        range_error;

   modport source (output valid, found, found_byte_addr, found_bit, run_length,
                   run_is_ones, range_error, input ready);
   modport sink   (input valid, found, found_byte_addr, found_bit, run_length,
                   run_is_ones, range_error, output ready);
endinterface

interface bsrs_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/bsrs_ctrl.sv -----
// Controller of the bitmap scanner: idle/scan state machine and response valid.
// Depends on bsrs_pkg; drives commands to bsrs_datapath and reads its status.
module bsrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  bsrs_pkg::kind_type   req_kind,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bsrs_pkg::status_type status,
   output bsrs_pkg::cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind) inside
                  bsrs_pkg::KIND_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  bsrs_pkg::KIND_FIND, bsrs_pkg::KIND_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (status.done) begin
               if (out_free) begin
                  cmd.finish   = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_start_enters_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == ST_SCAN)
      else $error("query start did not enter scan");

   a_finish_presents_word: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished query did not present a response word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.finish)
      else $error("pending response word overwritten");

endmodule

// ----- rtl/bsrs_datapath.sv -----
// Datapath of the bitmap scanner: bitmap memory, ceiling register, byte scan and result.
// Depends on bsrs_pkg; controlled by bsrs_ctrl through command and status structs.
module bsrs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bsrs_pkg::cmd_type    cmd,
   output bsrs_pkg::status_type status,
   input  bsrs_pkg::kind_type   req_kind,
   input  logic [11:0]          req_byte_index,
   input  logic [7:0]           req_byte_value,
   input  logic [2:0]           req_start_bit,
   input  logic                 csr_write,
   input  logic [12:0]          csr_data,
   output logic                 rsp_found,
   output logic [11:0]          rsp_found_byte_addr,
   output logic [2:0]           rsp_found_bit,
   output logic [15:0]          rsp_run_length,
   output logic                 rsp_run_is_ones,
   output logic                 rsp_range_error
);

   logic [7:0] bitmap_ff [bsrs_pkg::BitmapBytes];

   logic [bsrs_pkg::CeilWidth-1:0]  ceiling_ff;
   logic [bsrs_pkg::CeilWidth-1:0]  ceil_eff;
   logic [7:0]                      rd_data_ff;
   logic [bsrs_pkg::AddrWidth-1:0]  eval_addr_ff;
   logic [bsrs_pkg::AddrWidth-1:0]  rd_addr;
   logic [bsrs_pkg::CeilWidth-1:0]  next_addr;
   logic [2:0]                      bit_ff;
   logic                            first_ff;
   logic                            pol_ff;
   logic                            range_ff;
   bsrs_pkg::kind_type              kind_ff;
   logic [bsrs_pkg::CountWidth-1:0] count_ff;
   logic [bsrs_pkg::CountWidth-1:0] run_sum;
   logic                            rd_en;
   logic                            at_end;
   logic [7:0]                      mask;
   logic [7:0]                      find_bits;
   logic                            pol_eff;
   logic [7:0]                      same_bits;
   logic [3:0]                      ones;
   logic [3:0]                      run_add;

   logic                            found_ff;
   logic [11:0]                     found_byte_addr_ff;
   logic [2:0]                      found_bit_ff;
   logic [15:0]                     run_length_ff;
   logic                            run_is_ones_ff;
   logic                            range_error_ff;

   assign ceil_eff  = (ceiling_ff > bsrs_pkg::CeilLimit) ? bsrs_pkg::CeilLimit : ceiling_ff;
   assign next_addr = bsrs_pkg::CeilWidth'(eval_addr_ff) + bsrs_pkg::CeilWidth'(1);
   assign at_end    = (next_addr >= ceil_eff);
   assign rd_en     = cmd.start || cmd.step;
   assign rd_addr   = cmd.start ? req_byte_index : next_addr[bsrs_pkg::AddrWidth-1:0];

   assign mask      = bsrs_pkg::low_mask(bit_ff);
   assign find_bits = rd_data_ff & ~mask;
   assign pol_eff   = first_ff ? rd_data_ff[bit_ff] : pol_ff;
   assign same_bits = pol_eff ? rd_data_ff : ~rd_data_ff;
   assign ones      = bsrs_pkg::trailing_ones(same_bits | mask);
   assign run_add   = ones - {1'b0, bit_ff};
   assign run_sum   = count_ff + bsrs_pkg::CountWidth'(run_add);

   always_comb begin
      if (kind_ff == bsrs_pkg::KIND_FIND) begin
         status.done = (find_bits != 8'h00) || at_end;
      end else begin
         status.done = range_ff || (ones != 4'd8) || at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bitmap_ff[req_byte_index] <= req_byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bitmap_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= bsrs_pkg::CeilReset;
      end else if (csr_write) begin
         ceiling_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         eval_addr_ff <= req_byte_index;
         bit_ff       <= req_start_bit;
         first_ff     <= 1'b1;
         pol_ff       <= 1'b0;
         kind_ff      <= req_kind;
         count_ff     <= '0;
         range_ff     <= (bsrs_pkg::CeilWidth'(req_byte_index) >= ceil_eff);
      end else if (cmd.step) begin
         eval_addr_ff <= next_addr[bsrs_pkg::AddrWidth-1:0];
         bit_ff       <= 3'd0;
         first_ff     <= 1'b0;
         pol_ff       <= pol_eff;
         count_ff     <= run_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         found_ff           <= 1'b0;
         found_byte_addr_ff <= '0;
         found_bit_ff       <= '0;
         run_length_ff      <= '0;
         run_is_ones_ff     <= 1'b0;
         range_error_ff     <= 1'b0;
         if (kind_ff == bsrs_pkg::KIND_FIND) begin
            if (find_bits != 8'h00) begin
               found_ff           <= 1'b1;
               found_byte_addr_ff <= eval_addr_ff;
               found_bit_ff       <= bsrs_pkg::lowest_set(find_bits);
            end
         end else if (range_ff) begin
            range_error_ff <= 1'b1;
         end else begin
            run_length_ff  <= run_sum;
            run_is_ones_ff <= pol_eff;
         end
      end
   end

   assign rsp_found           = found_ff;
   assign rsp_found_byte_addr = found_byte_addr_ff;
   assign rsp_found_bit       = found_bit_ff;
   assign rsp_run_length      = run_length_ff;
   assign rsp_run_is_ones     = run_is_ones_ff;
   assign rsp_range_error     = range_error_ff;

endmodule

// ----- rtl/bitmap_set_bit_and_run_scanner_unit.sv -----
// Top level of the bitmap set-bit and run scanner.
// Depends on bsrs_pkg, bsrs_if, bsrs_ctrl and bsrs_datapath.
//
// The request channel carries one word per item. A load word writes one byte of the
// 4096-byte bitmap and produces no response. A find word searches for the first set
// bit at or after its start bit, and a run word counts contiguous bits equal to its
// start bit; both stop before the ceiling byte and return one response word.
// The control-register channel writes the ceiling; it is always ready, and the user must
// write it only while the unit is idle, which the block itself does not enforce.
// A query examines one bitmap byte per cycle through the single read port of the
// bitmap memory, at least one byte per query, and registers its response word after
// the last byte; no further request is taken until the query has finished.
// The response sits in an output register, so requests are still taken while it waits.
// If the receiver stalls and a second query finishes, that query holds its last byte
// until the register frees. Reset clears the state machine, the response valid and
// sets the ceiling to 4096; bitmap contents are undefined until loaded.
module bitmap_set_bit_and_run_scanner_unit (
   input  logic       clock,
   input  logic       reset,
   bsrs_req_if.sink   req_ch,
   bsrs_rsp_if.source rsp_ch,
   bsrs_csr_if.sink   csr_ch
);

   bsrs_pkg::cmd_type    cmd;
   bsrs_pkg::status_type status;
   bsrs_pkg::kind_type   req_kind;

   assign req_kind     = bsrs_pkg::kind_type'(req_ch.kind);
   assign csr_ch.ready = 1'b1;

   bsrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_kind),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsrs_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_kind),
      .req_byte_index      (req_ch.byte_index),
      .req_byte_value      (req_ch.byte_value),
      .req_start_bit       (req_ch.start_bit),
      .csr_write           (csr_ch.valid),
      .csr_data            (csr_ch.data),
      .rsp_found           (rsp_ch.found),
      .rsp_found_byte_addr (rsp_ch.found_byte_addr),
      .rsp_found_bit       (rsp_ch.found_bit),
      .rsp_run_length      (rsp_ch.run_length),
      .rsp_run_is_ones     (rsp_ch.run_is_ones),
      .rsp_range_error     (rsp_ch.range_error)
   );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_set_bit_and_run_scanner_unit.
// Drives load, find and run words, predicts every response from a shadow copy of the bitmap
// and compares it; depends on bsrs_pkg, bsrs_if and the unit itself.

typedef struct packed {
   bsrs_pkg::kind_type                 kind;
   logic [bsrs_pkg::AddrWidth-1:0]     byte_index;
   logic [7:0]                         byte_value;
   logic [2:0]                         start_bit;
} scan_request_type;

typedef struct packed {
   logic                               found;
   logic [bsrs_pkg::AddrWidth-1:0]     found_byte_addr;
   logic [2:0]                         found_bit;
   logic [bsrs_pkg::CountWidth-1:0]    run_length;
   logic                               run_is_ones;
   logic                               range_error;
} scan_result_type;

class bitmap_scan_board;
   logic [7:0]                     bitmap [bsrs_pkg::BitmapBytes];
   bit                             loaded [bsrs_pkg::BitmapBytes];
   logic [bsrs_pkg::CeilWidth-1:0] ceiling;
   scan_result_type                awaited_results [$];
   int                             mismatches;

   function new();
      foreach (bitmap[i]) begin
         bitmap[i] = 8'h00;
         loaded[i] = 1'b0;
      end
      ceiling    = bsrs_pkg::CeilReset;
      mismatches = 0;
   endfunction

   // Returns 1 when the query reads only bytes that have been loaded.
   function bit predict_scan(input scan_request_type w, output scan_result_type r);
      int unsigned lim;
      int unsigned p;
      int unsigned bpos;
      int unsigned count;
      logic [7:0]  b;
      logic        pol;
      bit          clean;
      r     = '0;
      clean = 1'b1;
      lim   = (ceiling < bsrs_pkg::CeilLimit) ? ceiling : bsrs_pkg::BitmapBytes;
      p     = w.byte_index;
      if (w.kind == bsrs_pkg::KIND_FIND) begin
         clean = loaded[p];
         b = bitmap[p] & (8'hFF << w.start_bit);
         while (clean && b == 8'h00 && p + 1 < lim) begin
            p++;
            clean = loaded[p];
            b = bitmap[p];
         end
         if (b != 8'h00) begin
            r.found           = 1'b1;
            r.found_byte_addr = p[bsrs_pkg::AddrWidth-1:0];
            for (int i = 0; i < 8; i++) begin
               if (b[i]) begin
                  r.found_bit = 3'(i);
                  break;
               end
            end
         end
      end else if (w.kind == bsrs_pkg::KIND_RUN) begin
         if (p >= lim) begin
            r.range_error = 1'b1;
         end else begin
            bpos  = w.start_bit;
            clean = loaded[p];
            pol   = bitmap[p][bpos];
            count = 0;
            while (clean && bitmap[p][bpos] == pol) begin
               count++;
               bpos++;
               if (bpos == 8) begin
                  bpos = 0;
                  p++;
                  if (p >= lim) break;
                  clean = loaded[p];
               end
            end
            r.run_length  = 16'(count);
            r.run_is_ones = pol;
         end
      end
      return clean;
   endfunction

   function void note_word(input scan_request_type w);
      scan_result_type r;
      if (w.kind == bsrs_pkg::KIND_LOAD) begin
         bitmap[w.byte_index] = w.byte_value;
         loaded[w.byte_index] = 1'b1;
      end else if (w.kind != bsrs_pkg::KIND_SPARE) begin
         void'(predict_scan(w, r));
         awaited_results.push_back(r);
      end
   endfunction

   function void check_word(input scan_result_type got);
      scan_result_type exp;
      if (awaited_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Unexpected response word: found=%0d addr=%0d bit=%0d %s%0d %s%0d %s%0d",
                     got.found, got.found_byte_addr, got.found_bit,
                     "run=", got.run_length, "ones=", got.run_is_ones,
                     "err=", got.range_error);
         return;
      end
      exp = awaited_results.pop_front();
      if (got.found !== exp.found || got.found_byte_addr !== exp.found_byte_addr ||
          got.found_bit !== exp.found_bit || got.run_length !== exp.run_length ||
          got.run_is_ones !== exp.run_is_ones || got.range_error !== exp.range_error) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch: expected found=%0d addr=%0d bit=%0d run=%0d ones=%0d err=%0d",
                     exp.found, exp.found_byte_addr, exp.found_bit, exp.run_length,
                     exp.run_is_ones, exp.range_error);
            $display("          actual   found=%0d addr=%0d bit=%0d run=%0d ones=%0d err=%0d",
                     got.found, got.found_byte_addr, got.found_bit, got.run_length,
                     got.run_is_ones, got.range_error);
         end
      end
   endfunction
endclass

module tb_top;
   localparam int CycleLimit = 1_000_000;
   localparam int HoldCycles = 600;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic clock;
   logic reset;
   logic start_hold;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_left;
   int   cycles = 0;

   bsrs_req_if req ();
   bsrs_rsp_if rsp ();
   bsrs_csr_if csr ();

   bitmap_scan_board board = new();

   bitmap_set_bit_and_run_scanner_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      scan_result_type got;
      rsp.ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            got.found           = rsp.found;
            got.found_byte_addr = rsp.found_byte_addr;
            got.found_bit       = rsp.found_bit;
            got.run_length      = rsp.run_length;
            got.run_is_ones     = rsp.run_is_ones;
            got.range_error     = rsp.range_error;
            board.check_word(got);
         end
         if (start_hold) hold_left = HoldCycles;
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] pick_value();
      logic [7:0] one;
      one = 8'h01 << $urandom_range(7);
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return one;
         3: return ~one;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_word(input scan_request_type w);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.kind       <= w.kind;
      req.byte_index <= w.byte_index;
      req.byte_value <= w.byte_value;
      req.start_bit  <= w.start_bit;
      do @(posedge clock); while (req.ready !== 1'b1);
      board.note_word(w);
   endtask

   task automatic put(input bsrs_pkg::kind_type k, input int addr, input logic [7:0] value,
                      input int sbit);
      scan_request_type w;
      w.kind       = k;
      w.byte_index = 12'(addr);
      w.byte_value = value;
      w.start_bit  = 3'(sbit);
      send_word(w);
   endtask

   task automatic settle();
      while (board.awaited_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_ceiling(input logic [bsrs_pkg::CeilWidth-1:0] value);
      settle();
      csr.valid <= 1'b1;
      csr.data  <= value;
      do @(posedge clock); while (csr.ready !== 1'b1);
      csr.valid <= 1'b0;
      board.ceiling = value;
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         IDLE_SEND: begin
            send_idle_pct = 82;
            recv_idle_pct = 0;
         end
         IDLE_RECV: begin
            send_idle_pct = 0;
            recv_idle_pct = 82;
         end
         default: begin
            send_idle_pct = 32;
            recv_idle_pct = 32;
         end
      endcase
   endtask

   task automatic directed_words();
      put(bsrs_pkg::KIND_LOAD, 0, 8'h00, 0);
      put(bsrs_pkg::KIND_LOAD, 1, 8'h00, 0);
      put(bsrs_pkg::KIND_LOAD, 2, 8'h30, 0);
      put(bsrs_pkg::KIND_LOAD, 3, 8'hFF, 0);
      put(bsrs_pkg::KIND_LOAD, 4, 8'h0F, 0);
      put(bsrs_pkg::KIND_LOAD, 4094, 8'hFF, 0);
      put(bsrs_pkg::KIND_LOAD, 4095, 8'h80, 0);
      put(bsrs_pkg::KIND_FIND, 0, 8'h00, 0);
      put(bsrs_pkg::KIND_FIND, 2, 8'hFF, 5);
      put(bsrs_pkg::KIND_FIND, 2, 8'h00, 6);
      put(bsrs_pkg::KIND_FIND, 4095, 8'h00, 7);
      put(bsrs_pkg::KIND_FIND, 4095, 8'h00, 0);
      put(bsrs_pkg::KIND_RUN, 3, 8'h00, 0);
      put(bsrs_pkg::KIND_RUN, 0, 8'h00, 0);
      put(bsrs_pkg::KIND_RUN, 4094, 8'h00, 0);
      put(bsrs_pkg::KIND_RUN, 4095, 8'h00, 7);
      put(bsrs_pkg::KIND_RUN, 4095, 8'h00, 0);
      put(bsrs_pkg::KIND_SPARE, 4095, 8'hFF, 7);
      req.valid <= 1'b0;
      write_ceiling(13'd0);
      put(bsrs_pkg::KIND_RUN, 0, 8'h00, 0);
      put(bsrs_pkg::KIND_FIND, 2, 8'h00, 6);
      put(bsrs_pkg::KIND_FIND, 4095, 8'h00, 7);
      req.valid <= 1'b0;
      write_ceiling(13'd1);
      put(bsrs_pkg::KIND_RUN, 0, 8'h00, 3);
      put(bsrs_pkg::KIND_FIND, 0, 8'h00, 0);
      req.valid <= 1'b0;
   endtask

   task automatic random_words(input int base, input int span, input int count,
                               input bit pause_midway);
      scan_request_type w;
      scan_result_type  r;
      int               sent;
      int               roll;
      bit               placed;
      bit               paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < count) begin
         if (pause_midway && !paused && sent >= count / 2) begin
            paused = 1'b1;
            req.valid <= 1'b0;
            @(posedge clock);
            while (board.awaited_results.size() != 0) @(posedge clock);
         end
         roll         = $urandom_range(99);
         w.byte_value = 8'($urandom);
         w.start_bit  = 3'($urandom);
         w.byte_index = 12'(base + $urandom_range(span - 1));
         if (roll < 4) begin
            w.kind       = bsrs_pkg::KIND_SPARE;
            w.byte_index = 12'($urandom);
         end else if (roll < 12) begin
            w.kind       = bsrs_pkg::KIND_LOAD;
            w.byte_index = 12'($urandom);
         end else if (roll < 45) begin
            w.kind       = bsrs_pkg::KIND_LOAD;
            w.byte_value = pick_value();
         end else begin
            placed = 1'b0;
            for (int t = 0; t < 8 && !placed; t++) begin
               w.kind      = $urandom_range(1) ? bsrs_pkg::KIND_RUN : bsrs_pkg::KIND_FIND;
               w.start_bit = 3'($urandom);
               if ($urandom_range(9) == 0) w.byte_index = 12'($urandom);
               else w.byte_index = 12'(base + $urandom_range(span - 1));
               placed = board.predict_scan(w, r);
            end
            if (!placed) begin
               w.kind       = bsrs_pkg::KIND_LOAD;
               w.byte_value = pick_value();
               w.byte_index = 12'(base + $urandom_range(span - 1));
               for (int a = base + span - 1; a >= base; a--) begin
                  if (!board.loaded[a]) w.byte_index = 12'(a);
               end
            end
         end
         send_word(w);
         if (w.kind != bsrs_pkg::KIND_SPARE) sent++;
      end
      req.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [bsrs_pkg::CeilWidth-1:0] ceil,
                            input idle_mode_type mode,
                            input int base, input int span, input int count,
                            input bit long_hold, input bit pause_midway);
      write_ceiling(ceil);
      set_idle(mode);
      if (long_hold) begin
         start_hold <= 1'b1;
         @(posedge clock);
         start_hold <= 1'b0;
      end
      random_words(base, span, count, pause_midway);
   endtask

   initial begin
      reset          <= 1'b1;
      start_hold     <= 1'b0;
      req.valid      <= 1'b0;
      req.kind       <= bsrs_pkg::KIND_LOAD;
      req.byte_index <= '0;
      req.byte_value <= '0;
      req.start_bit  <= '0;
      csr.valid      <= 1'b0;
      csr.data       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_words();
      run_phase(13'd48,   IDLE_NONE, 0,    64,  120, 1'b0, 1'b0);
      run_phase(13'd8191, IDLE_SEND, 4032, 64,  120, 1'b0, 1'b0);
      run_phase(13'd1,    IDLE_RECV, 0,    16,  60,  1'b0, 1'b0);
      run_phase(13'd0,    IDLE_BOTH, 0,    16,  60,  1'b0, 1'b0);
      run_phase(13'd4096, IDLE_RECV, 4040, 56,  120, 1'b1, 1'b0);
      run_phase(13'($urandom_range(2, 200)), IDLE_BOTH, 0, 256, 120, 1'b0, 1'b1);
      run_phase(13'd4097, IDLE_SEND, 1000, 64,  100, 1'b0, 1'b0);
      run_phase(13'd4095, IDLE_NONE, 4000, 96,  100, 1'b1, 1'b1);
      while (board.awaited_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
